// File: design/bounded_edit_distance_match_assert.svh
// Assertion macros used by the datapath (bedm_dp) of the bounded edit distance matcher.
`ifndef BOUNDED_EDIT_DISTANCE_MATCH_ASSERT_SVH
`define BOUNDED_EDIT_DISTANCE_MATCH_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BEDM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bedm assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define BEDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bedm assertion failed");

`endif

// File: design/bedm_pkg.sv
// Package: constants, command/status types and helpers of the edit distance matcher.
package bedm_pkg;

  localparam int unsigned MAX_QUERY_LEN = 16;
  localparam int unsigned THR_RESET     = 2;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned DIST_W        = 5;
  localparam int unsigned THR_W         = 4;
  localparam logic [DIST_W-1:0] CELL_MAX = 5'd31;

  // Input command codes
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_CAND  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic query_wr;
    logic cand_start;
    logic step;
    logic emit;
  } bedm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic qlen_zero;
    logic step_last;
    logic out_free;
  } bedm_sts_t;

  // Saturating increment of a row cell
  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
    sat_inc = (v >= CELL_MAX) ? CELL_MAX : v + 5'd1;
  endfunction

endpackage

// File: design/bedm_in_if.sv
// Input channel interface: one query or candidate character per item.
interface bedm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [bedm_pkg::CH_W-1:0]   ch;
  logic                        last;

  modport source (output valid, output cmd, output ch, output last, input ready);
  modport sink   (input valid, input cmd, input ch, input last, output ready);
endinterface

// File: design/bedm_out_if.sv
// Output channel interface: one match result per item.
interface bedm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          match;
  logic [bedm_pkg::DIST_W-1:0]   distance;
  logic                          query_bad;

  modport source (output valid, output match, output distance, output query_bad,
                  input ready);
  modport sink   (input valid, input match, input distance, input query_bad,
                  output ready);
endinterface

// File: design/bounded_edit_distance_match.sv
// Bounded edit distance matcher: a stored query is compared against streamed
// candidate names by the Levenshtein row recurrence, one character per item.
// A query character is stored as soon as it is accepted. A candidate character is
// accepted, then the cell update unit computes one row cell per cycle from the
// query memory and the row memory, one cell for each stored query character; on a
// candidate's last character the result register is then loaded. A result waiting
// in the output register does not block new items until the next result is ready.
// A distance strictly below the configured threshold on a valid query sets match.
module bounded_edit_distance_match #(
  parameter int unsigned MAX_QUERY_LEN = bedm_pkg::MAX_QUERY_LEN
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bedm_pkg::THR_W-1:0]  cfg_wdata_i,
  bedm_in_if.sink                     in_ch,
  bedm_out_if.source                  out_ch
);

  bedm_pkg::bedm_cmd_t cmd;
  bedm_pkg::bedm_sts_t sts;

  // Sequence each character
  bedm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_cmd_i   (in_ch.cmd),
    .in_last_i  (in_ch.last),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store the query, update the row, hold the result
  bedm_dp #(
    .MAX_QUERY_LEN (MAX_QUERY_LEN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_ch_i         (in_ch.ch),
    .in_last_i       (in_ch.last),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_match_o     (out_ch.match),
    .out_distance_o  (out_ch.distance),
    .out_query_bad_o (out_ch.query_bad)
  );

endmodule

// File: design/bedm_ctrl.sv
// Controller state machine: sequences the per-cell row update of one character.
module bedm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_cmd_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  bedm_pkg::bedm_sts_t sts_i,
  output bedm_pkg::bedm_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_e;

  state_e state_q;
  logic   last_q;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Decode commands for the datapath
  always_comb begin
    cmd_o.query_wr   = accept && (in_cmd_i == bedm_pkg::CMD_QUERY);
    cmd_o.cand_start = accept && (in_cmd_i == bedm_pkg::CMD_CAND);
    cmd_o.step       = (state_q == S_RUN);
    cmd_o.emit       = (state_q == S_FIN) && sts_i.out_free;
  end

  // Hold state and the last flag of the candidate character in progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.cand_start) begin
            last_q <= in_last_i;
            if (!sts_i.qlen_zero) begin
              state_q <= S_RUN;
            end else if (in_last_i) begin
              state_q <= S_FIN;
            end
          end
        end
        S_RUN: begin
          if (sts_i.step_last) begin
            state_q <= last_q ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/bedm_dp.sv
// Datapath: query store, DP row memory, cell update unit and result register.
`include "bounded_edit_distance_match_assert.svh"

module bedm_dp #(
  parameter int unsigned MAX_QUERY_LEN = bedm_pkg::MAX_QUERY_LEN
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bedm_pkg::THR_W-1:0]     cfg_wdata_i,
  input  logic [bedm_pkg::CH_W-1:0]      in_ch_i,
  input  logic                           in_last_i,
  input  bedm_pkg::bedm_cmd_t            cmd_i,
  output bedm_pkg::bedm_sts_t            sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_match_o,
  output logic [bedm_pkg::DIST_W-1:0]    out_distance_o,
  output logic                           out_query_bad_o
);

  localparam int unsigned IW = $clog2(MAX_QUERY_LEN);
  localparam int unsigned LW = $clog2(MAX_QUERY_LEN + 1);
  localparam int unsigned DW = bedm_pkg::DIST_W;

  // Query characters and row cells 1..MAX_QUERY_LEN (cell k at address k-1)
  logic [bedm_pkg::CH_W-1:0] qmem [MAX_QUERY_LEN];
  logic [DW-1:0]             rmem [MAX_QUERY_LEN];

  logic [MAX_QUERY_LEN-1:0]  row_vld_q;
  logic [DW-1:0]             cell0_q;
  logic [LW-1:0]             len_q;
  logic                      ovf_q;
  logic                      done_q;
  logic [bedm_pkg::THR_W-1:0] thr_q;
  logic [IW-1:0]             j_q;
  logic [DW-1:0]             diag_q;
  logic [DW-1:0]             left_q;
  logic                      rdv_q;
  logic [DW-1:0]             rd_q;
  logic [bedm_pkg::CH_W-1:0] qc_q;
  logic [bedm_pkg::CH_W-1:0] ch_q;
  logic                      out_vld_q;
  logic                      out_match_q;
  logic [DW-1:0]             out_dist_q;
  logic                      out_bad_q;

  logic [LW-1:0]             len_eff;
  logic                      wr_ok;
  logic [IW-1:0]             raddr;
  logic [7:0]                k_up;
  logic [DW-1:0]             up_init;
  logic [DW-1:0]             up;
  logic [DW-1:0]             best;
  logic [DW-1:0]             new_cell;
  logic                      bad;

  // Length after an optional restart of the query
  assign len_eff = done_q ? '0 : len_q;
  assign wr_ok   = (len_eff < LW'(MAX_QUERY_LEN));

  // Prefetch address: first cell on start, next cell on each step
  assign raddr = cmd_i.cand_start ? '0 : j_q + IW'(1);

  // Old value of cell j+1: stored value, or its initial value k saturated at 31
  assign k_up    = 8'(j_q) + 8'd1;
  assign up_init = (k_up > 8'(bedm_pkg::CELL_MAX)) ? bedm_pkg::CELL_MAX : k_up[DW-1:0];
  assign up      = rdv_q ? rd_q : up_init;

  // Cell update: copy diagonal on a character match, else 1 + min of three
  always_comb begin
    best = diag_q;
    if (up < best) begin
      best = up;
    end
    if (left_q < best) begin
      best = left_q;
    end
    new_cell = (qc_q == ch_q) ? diag_q : bedm_pkg::sat_inc(best);
  end

  assign bad = (len_q == '0) || ovf_q;

  // Status for the controller
  always_comb begin
    sts_o.qlen_zero = (len_q == '0);
    sts_o.step_last = ((LW'(j_q) + LW'(1)) == len_q);
    sts_o.out_free  = !out_vld_q || out_ready_i;
  end

  // Write and read the query and row memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_wr && wr_ok) begin
      qmem[len_eff[IW-1:0]] <= in_ch_i;
    end
    if (cmd_i.step) begin
      rmem[j_q] <= new_cell;
    end
    if (cmd_i.cand_start || cmd_i.step) begin
      qc_q <= qmem[raddr];
      rd_q <= rmem[raddr];
    end
  end

  // Hold candidate character and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cand_start) begin
      ch_q <= in_ch_i;
    end
    if (cmd_i.emit) begin
      out_match_q <= !bad && (left_q < DW'(thr_q));
      out_dist_q  <= left_q;
      out_bad_q   <= bad;
    end
  end

  // Advance query state, row state and the output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      cell0_q   <= '0;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      done_q    <= 1'b0;
      thr_q     <= bedm_pkg::THR_W'(bedm_pkg::THR_RESET);
      j_q       <= '0;
      diag_q    <= '0;
      left_q    <= '0;
      rdv_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.query_wr) begin
        if (wr_ok) begin
          len_q <= len_eff + LW'(1);
          ovf_q <= done_q ? 1'b0 : ovf_q;
        end else begin
          ovf_q <= 1'b1;
        end
        done_q    <= in_last_i;
        row_vld_q <= '0;
        cell0_q   <= '0;
      end
      if (cmd_i.cand_start) begin
        diag_q  <= cell0_q;
        left_q  <= bedm_pkg::sat_inc(cell0_q);
        cell0_q <= bedm_pkg::sat_inc(cell0_q);
        j_q     <= '0;
      end
      if (cmd_i.cand_start || cmd_i.step) begin
        rdv_q <= row_vld_q[raddr];
      end
      if (cmd_i.step) begin
        row_vld_q[j_q] <= 1'b1;
        left_q         <= new_cell;
        diag_q         <= up;
        j_q            <= j_q + IW'(1);
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
        row_vld_q <= '0;
        cell0_q   <= '0;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_match_o     = out_match_q;
  assign out_distance_o  = out_dist_q;
  assign out_query_bad_o = out_bad_q;

  // A step never runs past the stored query length
  `BEDM_ASSERT_NOW(a_step_in_range, clk_i, rst_ni, cmd_i.step, (LW'(j_q) < len_q))
  // An emitted result shows up in the output register
  `BEDM_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, cmd_i.emit, out_vld_q)
  // A query character resets the DP row
  `BEDM_ASSERT_NEXT(a_query_row_init, clk_i, rst_ni, cmd_i.query_wr,
                    (row_vld_q == '0) && (cell0_q == '0))

endmodule

// File: verif/bedm_match_checker.sv
// Checker for the edit distance matcher: predicts each result and compares it.
`timescale 1ns / 100ps

module bedm_match_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bedm_pkg::THR_W-1:0] cfg_wdata_i,
  bedm_in_if                         in_ch,
  bedm_out_if                        out_ch,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int unsigned QLEN = bedm_pkg::MAX_QUERY_LEN;
  localparam int unsigned DW   = bedm_pkg::DIST_W;
  localparam logic [DW-1:0] CELL_TOP = '1;

  typedef struct packed {
    logic          match;
    logic [DW-1:0] distance;
    logic          query_bad;
  } dist_result_t;

  // Predictor copy of the matcher state
  logic [bedm_pkg::CH_W-1:0]  query_buf [QLEN];
  int unsigned                query_len;
  logic                       query_over;
  logic                       query_closed;
  logic [DW-1:0]              dist_row [QLEN+1];
  logic [bedm_pkg::THR_W-1:0] threshold;

  dist_result_t expected_results [$];
  int           n_fail = 0;

  assign fail_count_o = n_fail;

  function automatic logic [DW-1:0] bump_cell(input logic [DW-1:0] v);
    return (v == CELL_TOP) ? v : v + 1'b1;
  endfunction

  // Restart the row: cell k holds k, capped at the top cell value
  function automatic void clear_row();
    for (int k = 0; k <= QLEN; k++) begin
      dist_row[k] = (k > int'(CELL_TOP)) ? CELL_TOP : k[DW-1:0];
    end
  endfunction

  // Advance the state by one item; return 1 when the item yields a result
  function automatic bit predict_distance(input logic cmd, input logic [bedm_pkg::CH_W-1:0] c,
                                          input logic last, output dist_result_t res);
    int unsigned   m;
    logic [DW-1:0] diag;
    logic [DW-1:0] up;
    logic [DW-1:0] left;
    logic [DW-1:0] best;
    logic          bad;
    res = '0;
    if (cmd == bedm_pkg::CMD_QUERY) begin
      // a character after a finished query starts a new one
      if (query_closed) begin
        query_len    = 0;
        query_over   = 1'b0;
        query_closed = 1'b0;
      end
      if (query_len < QLEN) begin
        query_buf[query_len] = c;
        query_len++;
      end else begin
        query_over = 1'b1;
      end
      if (last) query_closed = 1'b1;
      clear_row();
      return 1'b0;
    end
    // one row of the recurrence against the stored characters
    m    = query_len;
    diag = dist_row[0];
    dist_row[0] = bump_cell(dist_row[0]);
    for (int k = 1; k <= m; k++) begin
      up   = dist_row[k];
      left = dist_row[k-1];
      if (query_buf[k-1] == c) begin
        dist_row[k] = diag;
      end else begin
        best = diag;
        if (up < best) best = up;
        if (left < best) best = left;
        dist_row[k] = bump_cell(best);
      end
      diag = up;
    end
    if (!last) return 1'b0;
    bad           = (query_len == 0) || query_over;
    res.distance  = dist_row[m];
    res.query_bad = bad;
    res.match     = !bad && (dist_row[m] < {1'b0, threshold});
    clear_row();
    return 1'b1;
  endfunction

  // Compare results, track the register, predict accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    dist_result_t got;
    dist_result_t want;
    dist_result_t res;
    if (!rst_ni) begin
      query_len    = 0;
      query_over   = 1'b0;
      query_closed = 1'b0;
      threshold    = bedm_pkg::THR_W'(bedm_pkg::THR_RESET);
      clear_row();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.match     = out_ch.match;
        got.distance  = out_ch.distance;
        got.query_bad = out_ch.query_bad;
        if (expected_results.size() == 0) begin
          $error("result with none expected: match %0d distance %0d query_bad %0d",
                 got.match, got.distance, got.query_bad);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          if (got.match !== want.match) begin
            $error("match: expected %0d, got %0d", want.match, got.match);
            n_fail++;
          end
          if (got.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, got.distance);
            n_fail++;
          end
          if (got.query_bad !== want.query_bad) begin
            $error("query_bad: expected %0d, got %0d", want.query_bad, got.query_bad);
            n_fail++;
          end
        end
      end
      if (cfg_we_i === 1'b1) threshold = cfg_wdata_i;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        if (predict_distance(in_ch.cmd, in_ch.ch, in_ch.last, res)) begin
          expected_results.push_back(res);
        end
      end
    end
    pending_o <= expected_results.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the edit distance matcher.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned QLEN           = bedm_pkg::MAX_QUERY_LEN;
  localparam int          SETTLE_CYCLES  = 4 * (QLEN + 2);
  localparam int          ITEMS_PER_PASS = 300;
  localparam int          N_PASSES       = 6;
  localparam int          LONG_HOLD      = 400;
  localparam int          CYCLE_LIMIT    = 1000000;

  typedef logic [bedm_pkg::CH_W-1:0] name_t [$];
  typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC } rx_mode_e;
  typedef enum int { EDIT_SUB, EDIT_INS, EDIT_DEL } edit_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [bedm_pkg::THR_W-1:0] cfg_wdata_i;
  int                         fail_count;
  int                         pending;

  bedm_in_if  in_ch ();
  bedm_out_if out_ch ();

  bounded_edit_distance_match i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  bedm_match_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  int                        items_sent    = 0;
  int                        burst_left    = 0;
  int                        hold_requests = 0;
  logic [bedm_pkg::CH_W-1:0] alpha_base;
  bit                        alpha_wide;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("bounded_edit_distance_match test failed");
    $finish;
  end

  // Receiver: random stall patterns, plus a long hold-off on request
  initial begin
    rx_mode_e mode;
    int       seg_left;
    int       period;
    int       hold_left;
    int       holds_done;
    mode       = RX_OPEN;
    seg_left   = 0;
    period     = 2;
    hold_left  = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(16, 160);
          period   = $urandom_range(2, 5);
        end
        seg_left--;
        case (mode)
          RX_OPEN:     out_ch.ready <= 1'b1;
          RX_COIN:     out_ch.ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 5) == 0);
          RX_PERIODIC: out_ch.ready <= (seg_left % period == 0);
          default:     out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Offer one item in bursts with random gaps, hold it until accepted
  task automatic send_item(input logic cmd, input logic [bedm_pkg::CH_W-1:0] c,
                           input logic last);
    int gap_len;
    if (burst_left == 0) begin
      gap_len = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap_len) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.ch    <= c;
    in_ch.last  <= last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_name(input logic cmd, input name_t name, input bit closed);
    for (int i = 0; i < name.size(); i++) begin
      send_item(cmd, name[i], closed && (i == name.size() - 1));
    end
  endtask

  // Wait for all results, then let a candidate row finish before going on
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [bedm_pkg::THR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [bedm_pkg::CH_W-1:0] pick_char();
    if (alpha_wide) return bedm_pkg::CH_W'($urandom_range(0, 255));
    return alpha_base + bedm_pkg::CH_W'($urandom_range(0, 3));
  endfunction

  // Mostly short queries over a four-letter alphabet, some past the maximum length
  function automatic name_t random_query();
    name_t q;
    int    r;
    int    len;
    r          = $urandom_range(0, 99);
    len        = (r < 70) ? $urandom_range(1, 6) :
                 (r < 92) ? $urandom_range(7, QLEN) : $urandom_range(QLEN + 1, QLEN + 4);
    alpha_wide = ($urandom_range(0, 4) == 0);
    alpha_base = bedm_pkg::CH_W'($urandom_range(0, 252));
    for (int i = 0; i < len; i++) q.push_back(pick_char());
    return q;
  endfunction

  // Derive a candidate by a few edits; now and then a long name to saturate
  function automatic name_t near_candidate(input name_t src);
    name_t q;
    int    pos;
    q = src;
    if ($urandom_range(0, 29) == 0) begin
      q.delete();
      repeat ($urandom_range(32, 40)) q.push_back(pick_char());
      return q;
    end
    repeat ($urandom_range(0, 4)) begin
      case (edit_e'($urandom_range(0, 2)))
        EDIT_SUB: if (q.size() > 0) q[$urandom_range(0, q.size() - 1)] = pick_char();
        EDIT_INS: begin
          pos = $urandom_range(0, q.size());
          q.insert(pos, pick_char());
        end
        EDIT_DEL: if (q.size() > 0) q.delete($urandom_range(0, q.size() - 1));
        default: ;
      endcase
    end
    if (q.size() == 0) q.push_back(pick_char());
    return q;
  endfunction

  // One query with its candidates; some groups are broken or plain noise
  task automatic send_group();
    name_t query;
    name_t part;
    int    r;
    int    split;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) begin
        send_item(($urandom_range(0, 1) == 1) ? bedm_pkg::CMD_CAND : bedm_pkg::CMD_QUERY,
                  bedm_pkg::CH_W'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
      end
    end else if (r < 16) begin
      // split query with a candidate in between, then an abandoned candidate
      query = random_query();
      split = $urandom_range(1, query.size());
      part  = query[0:split-1];
      send_name(bedm_pkg::CMD_QUERY, part, 1'b0);
      send_name(bedm_pkg::CMD_CAND, near_candidate(part), 1'b1);
      part = query[split:$];
      send_name(bedm_pkg::CMD_QUERY, part, 1'b1);
      send_name(bedm_pkg::CMD_CAND, near_candidate(query), 1'b0);
    end else begin
      query = random_query();
      send_name(bedm_pkg::CMD_QUERY, query, 1'b1);
      repeat ($urandom_range(1, 6)) send_name(bedm_pkg::CMD_CAND, near_candidate(query), 1'b1);
    end
  endtask

  initial begin
    int                         stop_at;
    logic [bedm_pkg::THR_W-1:0] thr;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= bedm_pkg::CMD_QUERY;
    in_ch.ch    <= '0;
    in_ch.last  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset threshold
    // candidates against the empty query after reset
    send_item(bedm_pkg::CMD_CAND, 8'h00, 1'b1);
    send_item(bedm_pkg::CMD_CAND, 8'hFF, 1'b0);
    send_item(bedm_pkg::CMD_CAND, 8'h80, 1'b1);
    // single character query, exact and two-edit candidates
    send_item(bedm_pkg::CMD_QUERY, 8'hFF, 1'b1);
    send_item(bedm_pkg::CMD_CAND, 8'hFF, 1'b1);
    send_item(bedm_pkg::CMD_CAND, 8'h00, 1'b0);
    send_item(bedm_pkg::CMD_CAND, 8'h7F, 1'b1);
    // candidate cut off by a new query, candidate against an unfinished query
    send_item(bedm_pkg::CMD_CAND, 8'h41, 1'b0);
    send_item(bedm_pkg::CMD_QUERY, 8'h41, 1'b0);
    send_item(bedm_pkg::CMD_CAND, 8'h41, 1'b1);
    send_item(bedm_pkg::CMD_QUERY, 8'h42, 1'b1);
    send_item(bedm_pkg::CMD_CAND, 8'h42, 1'b0);
    send_item(bedm_pkg::CMD_CAND, 8'h41, 1'b1);
    send_item(bedm_pkg::CMD_CAND, 8'h41, 1'b0);
    send_item(bedm_pkg::CMD_CAND, 8'h42, 1'b1);
    drain_results();

    // Random passes, each under its own threshold
    for (int p = 0; p < N_PASSES; p++) begin
      case (p)
        0:       thr = '1;
        1:       thr = '0;
        2:       thr = 4'd1;
        default: thr = bedm_pkg::THR_W'($urandom_range(0, 15));
      endcase
      write_threshold(thr);
      // receiver holds off while the sender keeps offering items
      if (p == 2) hold_requests <= hold_requests + 1;
      stop_at = items_sent + ITEMS_PER_PASS;
      while (items_sent < stop_at) send_group();
      drain_results();
    end

    if (fail_count == 0) begin
      $display("bounded_edit_distance_match test passed");
    end else begin
      $display("bounded_edit_distance_match test failed");
    end
    $finish;
  end

endmodule
